@@ sv/scf_pkg.sv @@
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types, constants and the quarter-wave sine table for the stereo
// chorus / flanger.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int DELAY_AW         = 12;
    localparam int DELAY_DEPTH      = 1 << DELAY_AW;
    localparam int SINE_AW          = 8;
    localparam int SINE_TABLE_DEPTH = 1 << SINE_AW;
    localparam int SINE_IW          = SINE_AW + 1;
    localparam int SINE_FRAC_W      = 30 - SINE_AW;

    localparam int SMP_W  = 24;
    localparam int DIV_W  = 28;
    localparam int RP_W   = DELAY_AW + 16;
    localparam int EXT_W  = (DIV_W > RP_W) ? DIV_W : RP_W;

    // x / 256e6 = (x >> 14) / 15625; the quotient by 15625 is
    // (n * RECIP_M) >> RECIP_SH, exact for n below 2^42
    localparam int DIVD_W      = 42;
    localparam int ACC_W       = 85;
    localparam int RECIP_SH    = 56;
    localparam int RECIP_STEPS = 4;
    localparam logic [42:0] RECIP_M = 43'd4611686018428;

    localparam logic [16:0] GAIN_ONE = 17'd65536;

    localparam logic [12:0] CHORUS_LO_US    = 13'd5000;
    localparam logic [14:0] CHORUS_SPAN_US  = 15'd25000;
    localparam logic [12:0] FLANGER_LO_US   = 13'd1000;
    localparam logic [14:0] FLANGER_SPAN_US = 15'd4000;

    localparam logic [EXT_W-1:0] D_MAX = EXT_W'(DELAY_DEPTH - 1) << 16;

    localparam logic [2:0] REG_DRY_WET     = 3'd0;
    localparam logic [2:0] REG_FB_GAIN     = 3'd1;
    localparam logic [2:0] REG_LFO_DEPTH   = 3'd2;
    localparam logic [2:0] REG_PHASE_STEP  = 3'd3;
    localparam logic [2:0] REG_R_OFFSET    = 3'd4;
    localparam logic [2:0] REG_EFFECT_MODE = 3'd5;
    localparam logic [2:0] REG_SAMPLE_RATE = 3'd6;

    localparam logic [16:0] RST_DRY_WET     = 17'd32768;
    localparam logic [15:0] RST_FB_GAIN     = 16'd32768;
    localparam logic [16:0] RST_LFO_DEPTH   = 17'd32768;
    localparam logic [30:0] RST_PHASE_STEP  = 31'd894785;
    localparam logic [15:0] RST_R_OFFSET    = 16'd0;
    localparam logic        RST_EFFECT_MODE = 1'b0;
    localparam logic [16:0] RST_SAMPLE_RATE = 17'd48000;

    typedef struct packed {
        logic [16:0] depth;
        logic [16:0] mix;
        logic [15:0] gain;
        logic        mode;
        logic [16:0] sample_rate;
    } scf_lane_cfg_t;

    typedef struct packed {
        logic start;
        logic take;
    } scf_ctrl_t;

    typedef struct packed {
        logic ready;
        logic done;
    } scf_stat_t;

    typedef logic [SINE_TABLE_DEPTH+1:0][23:0] sine_tbl_t;

    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [63:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[SMP_W-1:0];
        return r;
    endfunction

    // sin(pi/2 * k / depth) from an odd 7th-order polynomial in Q30
    function automatic sine_tbl_t build_sine();
        sine_tbl_t tbl;
        longint    t;
        longint    t2;
        longint    r;
        int        k;
        tbl = '0;
        for (k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            t  = longint'(k) << (30 - SINE_AW);
            t2 = (t * t) >>> 30;
            r  = -64'sd5026996;
            r  = 64'sd85569306 + ((r * t2) >>> 30);
            r  = -64'sd693598668 + ((r * t2) >>> 30);
            r  = 64'sd1686629713 + ((r * t2) >>> 30);
            r  = ((r * t) >>> 30) >>> 7;
            if (r < 0)
                r = 0;
            if (r > 64'sd8388608)
                r = 64'sd8388608;
            tbl[k] = r[23:0];
        end
        tbl[SINE_TABLE_DEPTH+1] = 24'd8388608;
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine();

endpackage

@@ sv/scf_lane.sv @@
// ----------------------------------------------------------------------------
// scf_lane
// One channel: delay ring, LFO sine lookup, delay-to-samples conversion by
// reciprocal multiplication, interpolated read, dry/wet mix and feedback.
// ----------------------------------------------------------------------------
module scf_lane
    import scf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  scf_ctrl_t                  ctrl,
    input  scf_lane_cfg_t              cfg,
    input  logic [DELAY_AW-1:0]        wr_pos,
    input  logic [31:0]                phase,
    input  logic signed [SMP_W-1:0]    sample_in,
    output scf_stat_t                  stat,
    output logic signed [SMP_W-1:0]    sample_out
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SINE   = 4'd2;
    localparam logic [3:0] S_DEPTH  = 4'd3;
    localparam logic [3:0] S_SPAN   = 4'd4;
    localparam logic [3:0] S_NUM    = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_ADDR   = 4'd8;
    localparam logic [3:0] S_RD0    = 4'd9;
    localparam logic [3:0] S_RD1    = 4'd10;
    localparam logic [3:0] S_RD2    = 4'd11;
    localparam logic [3:0] S_MIXA   = 4'd12;
    localparam logic [3:0] S_MIXB   = 4'd13;
    localparam logic [3:0] S_MIXC   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0]                 state_reg;
    logic [3:0]                 state_next;
    logic [DELAY_AW-1:0]        clr_reg;
    logic [1:0]                 cnt_reg;
    logic signed [SMP_W-1:0]    fb_reg;

    logic [SMP_W-1:0]           mem [DELAY_DEPTH];
    logic [SMP_W-1:0]           rd_data_reg;
    logic [DELAY_AW-1:0]        rd_addr;
    logic                       wr_en;
    logic [DELAY_AW-1:0]        wr_addr;
    logic signed [SMP_W-1:0]    wr_data;

    logic [31:0]                phase_reg;
    logic signed [SMP_W-1:0]    in_reg;
    logic signed [24:0]         sv_reg;
    logic [24:0]                u_reg;
    logic [38:0]                mt_reg;
    logic [36:0]                p0_reg;
    logic [35:0]                p1_reg;
    logic [DIVD_W-1:0]          n_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [DELAY_AW-1:0]        x_reg;
    logic [15:0]                f_reg;
    logic signed [SMP_W-1:0]    a_reg;
    logic signed [SMP_W-1:0]    wet_reg;
    logic signed [41:0]         pd_reg;
    logic signed [41:0]         pw_reg;
    logic signed [SMP_W-1:0]    out_reg;

    // sine lookup
    logic [1:0]                 quad;
    logic [30:0]                p_raw;
    logic [30:0]                p_m;
    logic [SINE_IW-1:0]         idx;
    logic [SINE_IW-1:0]         idx1;
    logic [SINE_FRAC_W-1:0]     sfrac;
    logic [23:0]                sa;
    logic [23:0]                sb;
    logic signed [24:0]         sdiff;
    logic signed [SINE_FRAC_W+25:0] sprod;
    logic signed [24:0]         sv;

    logic signed [42:0]         ds;
    logic signed [42:0]         u_wide;
    logic [12:0]                lo_us;
    logic [14:0]                span_us;
    logic [39:0]                us_prod;
    logic [38:0]                mt;
    logic [55:0]                num;
    logic [20:0]                pp_a;
    logic [21:0]                pp_b;
    logic [42:0]                pp;
    logic [ACC_W-1:0]           pp_sh;
    logic [EXT_W-1:0]           d_ext;
    logic [EXT_W-1:0]           d_clip;
    logic [RP_W-1:0]            rp;
    logic signed [24:0]         wdiff;
    logic signed [41:0]         wprod;
    logic signed [SMP_W-1:0]    wet;
    logic [16:0]                mix_inv;
    logic signed [40:0]         fb_prod;
    logic signed [42:0]         mix_sum;

    always_comb
    begin
        quad   = phase_reg[31:30];
        p_raw  = {1'b0, phase_reg[29:0]};
        p_m    = quad[0] ? (31'h4000_0000 - p_raw) : p_raw;
        idx    = p_m[30:30-SINE_AW];
        idx1   = SINE_IW'(idx + 1'b1);
        sfrac  = p_m[SINE_FRAC_W-1:0];
        sa     = SINE_TBL[idx];
        sb     = SINE_TBL[idx1];
        sdiff  = $signed({1'b0, sb}) - $signed({1'b0, sa});
        sprod  = sdiff * $signed({1'b0, sfrac});
        sv     = $signed({1'b0, sa}) + 25'(sprod >>> SINE_FRAC_W);
        if (quad[1])
            sv = -sv;

        ds      = sv_reg * $signed({1'b0, cfg.depth});
        u_wide  = (ds >>> 16) + 43'sd8388608;

        lo_us   = cfg.mode ? FLANGER_LO_US : CHORUS_LO_US;
        span_us = cfg.mode ? FLANGER_SPAN_US : CHORUS_SPAN_US;
        us_prod = u_reg * span_us;
        mt      = (39'(lo_us) << 24) + us_prod[38:0];

        num     = {p1_reg, 20'h0} + 56'(p0_reg);

        // one partial product of n * RECIP_M per step
        case (cnt_reg)
            2'd0:
            begin
                pp_a = n_reg[20:0];
                pp_b = RECIP_M[21:0];
            end
            2'd1:
            begin
                pp_a = n_reg[20:0];
                pp_b = {1'b0, RECIP_M[42:22]};
            end
            2'd2:
            begin
                pp_a = n_reg[41:21];
                pp_b = RECIP_M[21:0];
            end
            default:
            begin
                pp_a = n_reg[41:21];
                pp_b = {1'b0, RECIP_M[42:22]};
            end
        endcase
        pp = pp_a * pp_b;
        case (cnt_reg)
            2'd0:    pp_sh = ACC_W'(pp);
            2'd1:    pp_sh = ACC_W'(pp) << 22;
            2'd2:    pp_sh = ACC_W'(pp) << 21;
            default: pp_sh = ACC_W'(pp) << 43;
        endcase

        d_ext   = EXT_W'(acc_reg[ACC_W-1:RECIP_SH]);
        d_clip  = (d_ext > D_MAX) ? D_MAX : d_ext;
        rp      = {wr_pos, 16'h0} - d_clip[RP_W-1:0];

        wdiff   = 25'(signed'(rd_data_reg)) - 25'(a_reg);
        wprod   = wdiff * $signed({1'b0, f_reg});
        wet     = a_reg + SMP_W'(wprod >>> 16);

        mix_inv = GAIN_ONE - cfg.mix;
        fb_prod = wet_reg * $signed({1'b0, cfg.gain});
        mix_sum = 43'(pd_reg) + 43'(pw_reg);
    end

    // delay ring
    always_comb
    begin
        wr_en   = (state_reg == S_CLEAR) || ((state_reg == S_IDLE) && ctrl.start);
        wr_addr = (state_reg == S_CLEAR) ? clr_reg : wr_pos;
        wr_data = (state_reg == S_CLEAR) ? '0 : sat24(64'(sample_in) + 64'(fb_reg));
        rd_addr = (state_reg == S_RD1) ? DELAY_AW'(x_reg + 1'b1) : x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_reg == '1) state_next = S_IDLE;
            S_IDLE:   if (ctrl.start) state_next = S_SINE;
            S_SINE:   state_next = S_DEPTH;
            S_DEPTH:  state_next = S_SPAN;
            S_SPAN:   state_next = S_NUM;
            S_NUM:    state_next = S_SUM;
            S_SUM:    state_next = S_DIV;
            S_DIV:    if (cnt_reg == 2'(RECIP_STEPS - 1)) state_next = S_ADDR;
            S_ADDR:   state_next = S_RD0;
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_RD2;
            S_RD2:    state_next = S_MIXA;
            S_MIXA:   state_next = S_MIXB;
            S_MIXB:   state_next = S_MIXC;
            S_MIXC:   state_next = S_DONE;
            S_DONE:   if (ctrl.take) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            fb_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= DELAY_AW'(clr_reg + 1'b1);
            if (state_reg == S_DIV)
                cnt_reg <= 2'(cnt_reg + 1'b1);
            else
                cnt_reg <= '0;
            if (state_reg == S_MIXA)
                fb_reg <= sat24(64'(fb_prod >>> 16));
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                phase_reg <= phase;
                in_reg    <= sample_in;
            end
            S_SINE:   sv_reg <= sv;
            S_DEPTH:  u_reg  <= u_wide[24:0];
            S_SPAN:   mt_reg <= mt;
            S_NUM:
            begin
                p0_reg <= mt_reg[19:0] * cfg.sample_rate;
                p1_reg <= mt_reg[38:20] * cfg.sample_rate;
            end
            S_SUM:
            begin
                n_reg   <= num[55:14];
                acc_reg <= '0;
            end
            S_DIV:    acc_reg <= acc_reg + pp_sh;
            S_ADDR:
            begin
                x_reg <= rp[RP_W-1:16];
                f_reg <= rp[15:0];
            end
            S_RD1:    a_reg   <= signed'(rd_data_reg);
            S_RD2:    wet_reg <= wet;
            S_MIXA:   pd_reg  <= in_reg * $signed({1'b0, mix_inv});
            S_MIXB:   pw_reg  <= wet_reg * $signed({1'b0, cfg.mix});
            S_MIXC:   out_reg <= sat24(64'(mix_sum >>> 16));
            default:  ;
        endcase
    end

    assign stat.ready = (state_reg == S_IDLE);
    assign stat.done  = (state_reg == S_DONE);
    assign sample_out = out_reg;

endmodule

@@ sv/stereo_chorus_flanger.sv @@
// ----------------------------------------------------------------------------
// stereo_chorus_flanger
// After reset both delay rings are cleared, one entry a cycle, through every
// entry; no word is accepted until then, configuration writes are. A word
// (one stereo pair) runs through the lane states from acceptance until its
// result enters the output register, among them the reciprocal
// multiplication that turns the LFO delay into samples. Both channels run in
// parallel lanes. The next word is accepted in the cycle after the result
// moves to the output register, while that result may still wait there.
// ----------------------------------------------------------------------------
module stereo_chorus_flanger
    import scf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [2:0]               cfg_index,
    input  logic [30:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [SMP_W-1:0]  left_in,
    input  logic signed [SMP_W-1:0]  right_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [SMP_W-1:0]  left_out,
    output logic signed [SMP_W-1:0]  right_out
);

    logic [16:0]             dwm_reg;
    logic [15:0]             gain_reg;
    logic [16:0]             depth_reg;
    logic [30:0]             step_reg;
    logic [15:0]             offs_reg;
    logic                    mode_reg;
    logic [16:0]             sr_reg;

    logic                    busy_reg;
    logic [31:0]             lfo_reg;
    logic [DELAY_AW-1:0]     wp_reg;
    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] left_out_reg;
    logic signed [SMP_W-1:0] right_out_reg;

    scf_lane_cfg_t           lane_cfg;
    scf_ctrl_t               ctrl;
    scf_stat_t               l_stat;
    scf_stat_t               r_stat;
    logic signed [SMP_W-1:0] l_res;
    logic signed [SMP_W-1:0] r_res;
    logic                    accept;
    logic                    take;
    logic [31:0]             phase_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwm_reg   <= RST_DRY_WET;
            gain_reg  <= RST_FB_GAIN;
            depth_reg <= RST_LFO_DEPTH;
            step_reg  <= RST_PHASE_STEP;
            offs_reg  <= RST_R_OFFSET;
            mode_reg  <= RST_EFFECT_MODE;
            sr_reg    <= RST_SAMPLE_RATE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DRY_WET:     dwm_reg   <= cfg_data[16:0];
                REG_FB_GAIN:     gain_reg  <= cfg_data[15:0];
                REG_LFO_DEPTH:   depth_reg <= cfg_data[16:0];
                REG_PHASE_STEP:  step_reg  <= cfg_data;
                REG_R_OFFSET:    offs_reg  <= cfg_data[15:0];
                REG_EFFECT_MODE: mode_reg  <= cfg_data[0];
                REG_SAMPLE_RATE: sr_reg    <= cfg_data[16:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        lane_cfg.depth       = (depth_reg > GAIN_ONE) ? GAIN_ONE : depth_reg;
        lane_cfg.mix         = (dwm_reg > GAIN_ONE) ? GAIN_ONE : dwm_reg;
        lane_cfg.gain        = gain_reg;
        lane_cfg.mode        = mode_reg;
        lane_cfg.sample_rate = sr_reg;
    end

    assign in_stall   = busy_reg || !(l_stat.ready && r_stat.ready);
    assign accept     = in_valid && !in_stall;
    assign take       = l_stat.done && r_stat.done && (!out_valid_reg || !out_stall);
    assign ctrl.start = accept;
    assign ctrl.take  = take;
    assign phase_r    = lfo_reg + {offs_reg, 16'h0};

    scf_lane u_lane_l
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg        (lane_cfg),
        .wr_pos     (wp_reg),
        .phase      (lfo_reg),
        .sample_in  (left_in),
        .stat       (l_stat),
        .sample_out (l_res)
    );

    scf_lane u_lane_r
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg        (lane_cfg),
        .wr_pos     (wp_reg),
        .phase      (phase_r),
        .sample_in  (right_in),
        .stat       (r_stat),
        .sample_out (r_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            lfo_reg       <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                lfo_reg  <= lfo_reg + 32'(step_reg);
            end
            else if (take)
            begin
                busy_reg <= 1'b0;
                wp_reg   <= DELAY_AW'(wp_reg + 1'b1);
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_out_reg  <= l_res;
            right_out_reg <= r_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (l_stat.done == r_stat.done) && (l_stat.ready == r_stat.ready))
        else $error("lanes out of step");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && !l_stat.ready)
        else $error("word accepted but lanes not started");

    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !l_stat.done)
        else $error("lane result without a word in flight");

    a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> wp_reg == DELAY_AW'($past(wp_reg) + 1'b1))
        else $error("write position did not advance");

endmodule
